// ===== rtl/core/llre_pkg.sv =====
`default_nettype none

package llre_pkg;

    localparam int MAX_ITEMS_DEFAULT = 1024;
    localparam int LEN_W             = 11;
    localparam int OP_W              = 3;
    localparam int ITEM_W            = 11;
    localparam int SUM_W             = 20;

    localparam logic [LEN_W-1:0] LIST_LENGTH_RESET = LEN_W'(1024);

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 3'd0,
        OP_LEFT  = 3'd1,
        OP_RIGHT = 3'd2,
        OP_SWAP  = 3'd3,
        OP_REV   = 3'd4,
        OP_SUM   = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_RD_X,
        ST_RD_Y,
        ST_PLAN,
        ST_JOIN,
        ST_SUM_WALK,
        ST_SUM_MUL,
        ST_SUM_FIX,
        ST_DONE
    } state_t;

    // relink pattern picked once the four neighbor links are known
    typedef enum logic [1:0] {
        JK_LEFT,
        JK_RIGHT,
        JK_SWAP_ADJ,
        JK_SWAP_FAR
    } join_t;

endpackage

`default_nettype wire

// ===== rtl/core/llre_ram.sv =====
`default_nettype none

module llre_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1025,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/llre_alu.sv =====
`default_nettype none

// shared add/subtract unit: walk accumulation and the reversal correction
module llre_alu (
    input  wire logic [llre_pkg::SUM_W-1:0] a,
    input  wire logic [llre_pkg::SUM_W-1:0] b,
    input  wire logic                       sub,
    output logic      [llre_pkg::SUM_W-1:0] y
);

    always_comb
    begin
        if (sub)
        begin
            y = a - b;
        end
        else
        begin
            y = a + b;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/llre_seq.sv =====
`default_nettype none

module llre_seq #(
    parameter int MAX_ITEMS = llre_pkg::MAX_ITEMS_DEFAULT,
    localparam int IDX_W = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_stall,
    input  wire logic [llre_pkg::OP_W-1:0]   op,
    input  wire logic [llre_pkg::ITEM_W-1:0] item_x,
    input  wire logic [llre_pkg::ITEM_W-1:0] item_y,
    input  wire logic [IDX_W-1:0]            n,
    input  wire logic                        res_free,
    output logic                             done,
    output logic      [llre_pkg::SUM_W-1:0]  sum,
    output logic      [IDX_W-1:0]            rd_addr,
    input  wire logic [IDX_W-1:0]            lft_rdata,
    input  wire logic [IDX_W-1:0]            rgt_rdata,
    output logic                             lft_we,
    output logic      [IDX_W-1:0]            lft_waddr,
    output logic      [IDX_W-1:0]            lft_wdata,
    output logic                             rgt_we,
    output logic      [IDX_W-1:0]            rgt_waddr,
    output logic      [IDX_W-1:0]            rgt_wdata,
    output logic      [llre_pkg::SUM_W-1:0]  alu_a,
    output logic      [llre_pkg::SUM_W-1:0]  alu_b,
    output logic                             alu_sub,
    input  wire logic [llre_pkg::SUM_W-1:0]  alu_y
);

    localparam int SUM_W  = llre_pkg::SUM_W;
    localparam int PROD_W = (2 * IDX_W + 1 > SUM_W + 1) ? 2 * IDX_W + 1 : SUM_W + 1;

    llre_pkg::state_t state_reg, state_next;
    llre_pkg::op_t    op_reg, op_next;
    llre_pkg::join_t  kind_reg, kind_next;
    logic [IDX_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [IDX_W-1:0] lx_reg, lx_next, rx_reg, rx_next;
    logic [IDX_W-1:0] ly_reg, ly_next, ry_reg, ry_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic             rev_reg, rev_next;

    logic [IDX_W-1:0] x_in, y_in;
    logic [IDX_W-1:0] ja, jb;
    logic             operands_ok;
    logic             go_left;
    logic             join_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= llre_pkg::ST_IDLE;
            rev_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rev_reg   <= rev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        kind_reg <= kind_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        lx_reg   <= lx_next;
        rx_reg   <= rx_next;
        ly_reg   <= ly_next;
        ry_reg   <= ry_next;
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign x_in = IDX_W'(item_x);
    assign y_in = IDX_W'(item_y);
    assign operands_ok = (item_x != '0) && (item_y != '0) && (item_x != item_y)
                      && (32'(item_x) <= 32'(n)) && (32'(item_y) <= 32'(n));

    // join endpoints for the current relink step
    always_comb
    begin
        ja = x_reg;
        jb = y_reg;
        case (kind_reg)
            llre_pkg::JK_LEFT:
            begin
                case (cnt_reg[1:0])
                    2'd0:    begin ja = lx_reg; jb = rx_reg; end
                    2'd1:    begin ja = ly_reg; jb = x_reg;  end
                    default: begin ja = x_reg;  jb = y_reg;  end
                endcase
            end
            llre_pkg::JK_RIGHT:
            begin
                case (cnt_reg[1:0])
                    2'd0:    begin ja = lx_reg; jb = rx_reg; end
                    2'd1:    begin ja = y_reg;  jb = x_reg;  end
                    default: begin ja = x_reg;  jb = ry_reg; end
                endcase
            end
            llre_pkg::JK_SWAP_ADJ:
            begin
                case (cnt_reg[1:0])
                    2'd0:    begin ja = lx_reg; jb = y_reg;  end
                    2'd1:    begin ja = y_reg;  jb = x_reg;  end
                    default: begin ja = x_reg;  jb = ry_reg; end
                endcase
            end
            default:
            begin
                case (cnt_reg[1:0])
                    2'd0:    begin ja = lx_reg; jb = y_reg;  end
                    2'd1:    begin ja = y_reg;  jb = rx_reg; end
                    2'd2:    begin ja = ly_reg; jb = x_reg;  end
                    default: begin ja = x_reg;  jb = ry_reg; end
                endcase
            end
        endcase
    end

    assign join_last = (kind_reg == llre_pkg::JK_SWAP_FAR) ? (cnt_reg[1:0] == 2'd3)
                                                           : (cnt_reg[1:0] == 2'd2);
    assign go_left   = (op_reg == llre_pkg::OP_LEFT) ^ rev_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        kind_next  = kind_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        lx_next    = lx_reg;
        rx_next    = rx_reg;
        ly_next    = ly_reg;
        ry_next    = ry_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        rev_next   = rev_reg;
        cmd_stall  = 1'b1;
        done       = 1'b0;
        rd_addr    = x_reg;
        lft_we     = 1'b0;
        lft_waddr  = ja;
        lft_wdata  = jb;
        rgt_we     = 1'b0;
        rgt_waddr  = ja;
        rgt_wdata  = jb;
        alu_a      = acc_reg;
        alu_b      = SUM_W'(rgt_rdata);
        alu_sub    = 1'b0;

        unique case (state_reg)
            llre_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                // odd-sum walk starts at the sentinel; everything else reads X first
                rd_addr = (llre_pkg::op_t'(op) == llre_pkg::OP_SUM) ? '0 : x_in;
                if (cmd_valid)
                begin
                    op_next  = llre_pkg::op_t'(op);
                    x_next   = x_in;
                    y_next   = y_in;
                    acc_next = '0;
                    case (llre_pkg::op_t'(op)) inside
                        llre_pkg::OP_INIT:
                        begin
                            rev_next   = 1'b0;
                            cnt_next   = '0;
                            state_next = llre_pkg::ST_INIT;
                        end
                        llre_pkg::OP_LEFT, llre_pkg::OP_RIGHT, llre_pkg::OP_SWAP:
                        begin
                            state_next = operands_ok ? llre_pkg::ST_RD_X : llre_pkg::ST_DONE;
                        end
                        llre_pkg::OP_REV:
                        begin
                            rev_next   = !rev_reg;
                            state_next = llre_pkg::ST_DONE;
                        end
                        llre_pkg::OP_SUM:
                        begin
                            cnt_next   = IDX_W'(1);
                            state_next = llre_pkg::ST_SUM_WALK;
                        end
                        default:
                        begin
                            state_next = llre_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            llre_pkg::ST_INIT:
            begin
                lft_we    = 1'b1;
                rgt_we    = 1'b1;
                lft_waddr = cnt_reg;
                rgt_waddr = cnt_reg;
                if (cnt_reg == '0)
                begin
                    lft_wdata = n;
                    rgt_wdata = IDX_W'(1);
                end
                else
                begin
                    lft_wdata = cnt_reg - IDX_W'(1);
                    rgt_wdata = (cnt_reg == n) ? '0 : cnt_reg + IDX_W'(1);
                end
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == n)
                begin
                    state_next = llre_pkg::ST_DONE;
                end
            end

            llre_pkg::ST_RD_X:
            begin
                rd_addr    = y_reg;
                lx_next    = lft_rdata;
                rx_next    = rgt_rdata;
                state_next = llre_pkg::ST_RD_Y;
            end

            llre_pkg::ST_RD_Y:
            begin
                ly_next    = lft_rdata;
                ry_next    = rgt_rdata;
                state_next = llre_pkg::ST_PLAN;
            end

            llre_pkg::ST_PLAN:
            begin
                cnt_next = '0;
                if (op_reg == llre_pkg::OP_SWAP)
                begin
                    state_next = llre_pkg::ST_JOIN;
                    if (ry_reg == x_reg)
                    begin
                        // Y sits just left of X: swap roles so X leads
                        x_next    = y_reg;
                        y_next    = x_reg;
                        lx_next   = ly_reg;
                        rx_next   = ry_reg;
                        ly_next   = lx_reg;
                        ry_next   = rx_reg;
                        kind_next = llre_pkg::JK_SWAP_ADJ;
                    end
                    else
                    begin
                        kind_next = (rx_reg == y_reg) ? llre_pkg::JK_SWAP_ADJ
                                                      : llre_pkg::JK_SWAP_FAR;
                    end
                end
                else if (go_left)
                begin
                    kind_next  = llre_pkg::JK_LEFT;
                    state_next = (x_reg == ly_reg) ? llre_pkg::ST_DONE : llre_pkg::ST_JOIN;
                end
                else
                begin
                    kind_next  = llre_pkg::JK_RIGHT;
                    state_next = (x_reg == ry_reg) ? llre_pkg::ST_DONE : llre_pkg::ST_JOIN;
                end
            end

            llre_pkg::ST_JOIN:
            begin
                // right[a] = b and left[b] = a in the same cycle, one RAM each
                rgt_we    = 1'b1;
                rgt_waddr = ja;
                rgt_wdata = jb;
                lft_we    = 1'b1;
                lft_waddr = jb;
                lft_wdata = ja;
                cnt_next  = cnt_reg + IDX_W'(1);
                if (join_last)
                begin
                    state_next = llre_pkg::ST_DONE;
                end
            end

            llre_pkg::ST_SUM_WALK:
            begin
                rd_addr = rgt_rdata;
                if (cnt_reg[0])
                begin
                    acc_next = alu_y;
                end
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == n)
                begin
                    state_next = (rev_reg && !n[0]) ? llre_pkg::ST_SUM_MUL : llre_pkg::ST_DONE;
                end
            end

            llre_pkg::ST_SUM_MUL:
            begin
                prod_next  = PROD_W'(n) * (PROD_W'(n) + PROD_W'(1));
                state_next = llre_pkg::ST_SUM_FIX;
            end

            llre_pkg::ST_SUM_FIX:
            begin
                alu_a      = prod_reg[SUM_W:1];
                alu_b      = acc_reg;
                alu_sub    = 1'b1;
                acc_next   = alu_y;
                state_next = llre_pkg::ST_DONE;
            end

            llre_pkg::ST_DONE:
            begin
                if (res_free)
                begin
                    done       = 1'b1;
                    state_next = llre_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = llre_pkg::ST_IDLE;
            end
        endcase
    end

    assign sum = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/linked_list_reorder_engine_core.sv =====
`default_nettype none

// Reverse and ignored ops go straight to the result; moves and swaps read X, read Y, plan,
// then relink; init writes every link; odd sum walks the right links, then fixes for a reversal.
// One item at a time, the next accepted in the same cycle as the result goes valid; the link
// RAMs and their single read port set the pace. A result may wait in the output register
// while the next item runs. Reset clears the control state, the reversal flag and
// list_length (back to 1024); link tables are undefined until an init.
module linked_list_reorder_engine_core #(
    parameter int MAX_ITEMS = llre_pkg::MAX_ITEMS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [llre_pkg::LEN_W-1:0]  list_length,
    input  wire logic                        cmd_valid,
    output logic                             cmd_stall,
    input  wire logic [llre_pkg::OP_W-1:0]   op,
    input  wire logic [llre_pkg::ITEM_W-1:0] item_x,
    input  wire logic [llre_pkg::ITEM_W-1:0] item_y,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic      [llre_pkg::SUM_W-1:0]  odd_sum
);

    localparam int IDX_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = llre_pkg::SUM_W;

    // configuration
    logic [llre_pkg::LEN_W-1:0] list_length_reg;
    logic [IDX_W-1:0]           n_eff;

    // result register
    logic             res_valid_reg;
    logic [SUM_W-1:0] odd_sum_reg;
    logic             res_free;

    // sequencer to RAMs and ALU
    logic             done;
    logic [SUM_W-1:0] seq_sum;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] lft_rdata, rgt_rdata;
    logic             lft_we, rgt_we;
    logic [IDX_W-1:0] lft_waddr, lft_wdata, rgt_waddr, rgt_wdata;
    logic [SUM_W-1:0] alu_a, alu_b, alu_y;
    logic             alu_sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= llre_pkg::LIST_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            list_length_reg <= list_length;
        end
    end

    // effective length: clamp to 1..MAX_ITEMS
    always_comb
    begin
        if (list_length_reg == '0)
        begin
            n_eff = IDX_W'(1);
        end
        else if (32'(list_length_reg) > 32'(MAX_ITEMS))
        begin
            n_eff = IDX_W'(MAX_ITEMS);
        end
        else
        begin
            n_eff = IDX_W'(list_length_reg);
        end
    end

    // output beat register; free when empty or being drained this cycle
    assign res_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            odd_sum_reg <= seq_sum;
        end
    end

    assign res_valid = res_valid_reg;
    assign odd_sum   = odd_sum_reg;

    llre_seq #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .op        (op),
        .item_x    (item_x),
        .item_y    (item_y),
        .n         (n_eff),
        .res_free  (res_free),
        .done      (done),
        .sum       (seq_sum),
        .rd_addr   (rd_addr),
        .lft_rdata (lft_rdata),
        .rgt_rdata (rgt_rdata),
        .lft_we    (lft_we),
        .lft_waddr (lft_waddr),
        .lft_wdata (lft_wdata),
        .rgt_we    (rgt_we),
        .rgt_waddr (rgt_waddr),
        .rgt_wdata (rgt_wdata),
        .alu_a     (alu_a),
        .alu_b     (alu_b),
        .alu_sub   (alu_sub),
        .alu_y     (alu_y)
    );

    // left links; both tables are read at the same address each cycle
    llre_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ITEMS + 1)
    ) u_left_ram (
        .clk   (clk),
        .we    (lft_we),
        .waddr (lft_waddr),
        .wdata (lft_wdata),
        .raddr (rd_addr),
        .rdata (lft_rdata)
    );

    // right links; also drive the odd-sum walk
    llre_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ITEMS + 1)
    ) u_right_ram (
        .clk   (clk),
        .we    (rgt_we),
        .waddr (rgt_waddr),
        .wdata (rgt_wdata),
        .raddr (rd_addr),
        .rdata (rgt_rdata)
    );

    llre_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

endmodule

`default_nettype wire
